// ----- hw/rtl/eift_pkg.sv -----
// shared types and constants of the event identifier filter table
package eift_pkg;

  localparam int OPC_W     = 3;   // command code width
  localparam int EVT_W     = 16;  // identifier width on the ports
  localparam int LVL_W     = 3;   // severity level field width
  localparam int LIDX_W    = 6;   // load position field width
  localparam int CNT_REG_W = 7;   // level count register width
  localparam int CFG_IDX_W = 3;   // configuration index width

  localparam logic [CNT_REG_W-1:0] CNT_RESET = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_SET_EN   = 3'd1,
    OP_QUERY    = 3'd2,
    OP_ITER_RST = 3'd3,
    OP_NEXT_DIS = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CNT_L1 = 3'd0,
    CFG_CNT_L2 = 3'd1,
    CFG_CNT_L3 = 3'd2,
    CFG_CNT_L4 = 3'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLR,    // sweep of the disable memory after reset
    ST_IDLE,
    ST_DISP,   // decode the latched command
    ST_LVL,    // open a level for search
    ST_MID,    // read probe at mid
    ST_MCMP,   // compare probe at mid
    ST_LO,
    ST_LCMP,
    ST_HI,
    ST_HCMP,
    ST_ITER,   // iterator: advance position
    ST_ICHK,   // iterator: test disable bit
    ST_OUT     // hand result to output register
  } state_t;

endpackage

// ----- hw/rtl/event_id_filter_table.sv -----
// event identifier filter table: four sorted severity tables with disable bits
//
// input channel (in_valid / in_stall): one command word per item; a word is
//   taken when in_valid is high and in_stall low. in_stall stays high while a
//   command is being worked on, so one command is in flight at a time
// result channel (out_valid / out_stall): exactly one result word per command,
//   held in an output register; a stalled result holds and the next command
//   may already be taken and worked on behind it
// config channel (cfg_valid / cfg_ready): writes a level count, always ready;
//   only to be written while no command is in flight
// sequencing: load, reset iterator and unused codes go from dispatch straight to the
//   output register. set enable and query binary-search levels four down to one with
//   one shared compare on the id memory read port, each probe a read state then a
//   compare state. next disabled scans the disable memory entry by entry, a position
//   state then a check state per entry, and a position state of its own at each
//   level change
// reset: counts go to 64, iterator to level one before its first entry, and
//   the disable memory is swept to all enabled, one entry a cycle, with in_stall
//   high; the id memory is not cleared and must be loaded before any search
module event_id_filter_table
  import eift_pkg::*;
#(
  parameter int LEVEL_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPC_W-1:0]     in_opcode,
  input  logic [EVT_W-1:0]     in_event_id,
  input  logic                 in_enable,
  input  logic [LVL_W-1:0]     in_load_level,
  input  logic [LIDX_W-1:0]    in_load_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     out_level_found,
  output logic                 out_is_enabled,
  output logic                 out_notify_registry,
  output logic [EVT_W-1:0]     out_reported_id,
  output logic                 out_iter_done,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_REG_W-1:0] cfg_data
);

  // stored identifier width: ports carry 16 bits at most
  localparam int KEY_W = (ID_WIDTH < EVT_W) ? ID_WIDTH : EVT_W;
  localparam int POS_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
  localparam int ADR_W = POS_W + 2;
  localparam int MEM_D = 4 * (1 << POS_W);

  // ---------------------------------------------------------------------
  // level count registers
  // ---------------------------------------------------------------------
  logic [CNT_REG_W-1:0] cnt_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cnt_r[i] <= CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CNT_L1: cnt_r[0] <= cfg_data;
        CFG_CNT_L2: cnt_r[1] <= cfg_data;
        CFG_CNT_L3: cnt_r[2] <= cfg_data;
        CFG_CNT_L4: cnt_r[3] <= cfg_data;
        default:    ;
      endcase
    end
  end

  // count saturated to the table depth
  function automatic logic [CNT_W-1:0] cnt_eff(input logic [CNT_REG_W-1:0] c);
    if (CMP_W'(c) > CMP_W'(LEVEL_DEPTH)) return CNT_W'(LEVEL_DEPTH);
    else return CNT_W'(c);
  endfunction

  // ---------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [ADR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [LVL_W-1:0]  iter_lvl_r, iter_lvl_nxt;
  logic [CNT_W-1:0]  iter_pos_r, iter_pos_nxt;   // next position to look at
  logic              out_valid_r;

  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic              en_r;
  logic [LVL_W-1:0]  ld_lvl_r;
  logic [LIDX_W-1:0] ld_idx_r;

  logic [1:0]        lidx_r, lidx_nxt;           // level under search, 0..3
  logic [POS_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;

  logic [LVL_W-1:0]  res_lvl_r, res_lvl_nxt;
  logic              res_en_r, res_en_nxt;
  logic              res_ntf_r, res_ntf_nxt;
  logic [EVT_W-1:0]  res_id_r, res_id_nxt;
  logic              res_done_r, res_done_nxt;

  logic [LVL_W-1:0]  out_lvl_r;
  logic              out_en_r, out_ntf_r, out_done_r;
  logic [EVT_W-1:0]  out_id_r;

  // ---------------------------------------------------------------------
  // memories: identifiers (no reset) and disable bits (swept after reset)
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] id_mem  [MEM_D];
  logic             dis_mem [MEM_D];
  logic [KEY_W-1:0] id_rd_r;
  logic             dis_rd_r;

  logic [ADR_W-1:0] rd_addr;
  logic             id_we;
  logic [ADR_W-1:0] id_wa;
  logic             dis_we, dis_wd;
  logic [ADR_W-1:0] dis_wa;

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= key_r;
    id_rd_r <= id_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dis_we) dis_mem[dis_wa] <= dis_wd;
    dis_rd_r <= dis_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // shared search unit
  // ---------------------------------------------------------------------
  logic [1:0]       iter_lidx;
  logic [1:0]       cnt_sel;
  logic [CNT_W-1:0] cur_cnt;
  logic [POS_W-1:0] mid, lo_upd, hi_upd, hit_pos, upd_gap;
  logic             key_eq, key_lt, narrow, last_lvl, iter_end;
  logic             ld_ok, out_load;

  assign iter_lidx = 2'(iter_lvl_r - 3'd1);
  // one read of the count array: iterator or search level
  assign cnt_sel   = (state_r == ST_ITER) ? iter_lidx : lidx_r;
  assign cur_cnt   = cnt_eff(cnt_r[cnt_sel]);

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign key_eq   = (id_rd_r == key_r);
  assign key_lt   = (id_rd_r > key_r);          // probe above key: pull hi down
  assign lo_upd   = key_lt ? lo_r : mid;
  assign hi_upd   = key_lt ? mid : hi_r;
  assign upd_gap  = hi_upd - lo_upd;
  assign narrow   = (upd_gap <= POS_W'(1));
  assign last_lvl = (lidx_r == 2'd0);
  assign iter_end = (iter_pos_r >= cur_cnt);

  always_comb begin
    case (state_r)
      ST_LCMP: hit_pos = lo_r;
      ST_HCMP: hit_pos = hi_r;
      default: hit_pos = mid;
    endcase
  end

  assign ld_ok = (ld_lvl_r >= 3'd1) && (ld_lvl_r <= 3'd4)
              && (32'(ld_idx_r) < LEVEL_DEPTH);

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_addr_r == ADR_W'(MEM_D - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_DISP;
      ST_DISP: begin
        case (op_r)
          OP_SET_EN, OP_QUERY: state_nxt = ST_LVL;
          OP_NEXT_DIS:         state_nxt = ST_ITER;
          default:             state_nxt = ST_OUT;
        endcase
      end
      ST_LVL: begin
        if (cur_cnt != '0)  state_nxt = ST_MID;
        else if (last_lvl)  state_nxt = ST_OUT;
      end
      ST_MID:  state_nxt = ST_MCMP;
      ST_MCMP: begin
        if (key_eq)      state_nxt = ST_OUT;
        else if (narrow) state_nxt = ST_LO;
        else             state_nxt = ST_MID;
      end
      ST_LO:   state_nxt = ST_LCMP;
      ST_LCMP: state_nxt = key_eq ? ST_OUT : ST_HI;
      ST_HI:   state_nxt = ST_HCMP;
      ST_HCMP: begin
        if (key_eq || last_lvl) state_nxt = ST_OUT;
        else                    state_nxt = ST_LVL;
      end
      ST_ITER: begin
        if (iter_lvl_r == '0)                        state_nxt = ST_OUT;
        else if (iter_end && iter_lvl_r == 3'd4)     state_nxt = ST_OUT;
        else if (!iter_end)                          state_nxt = ST_ICHK;
      end
      ST_ICHK: state_nxt = dis_rd_r ? ST_OUT : ST_ITER;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // datapath and memory controls
  // ---------------------------------------------------------------------
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    iter_lvl_nxt = iter_lvl_r;
    iter_pos_nxt = iter_pos_r;
    lidx_nxt     = lidx_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    res_lvl_nxt  = res_lvl_r;
    res_en_nxt   = res_en_r;
    res_ntf_nxt  = res_ntf_r;
    res_id_nxt   = res_id_r;
    res_done_nxt = res_done_r;
    rd_addr      = {lidx_r, mid};
    id_we        = 1'b0;
    id_wa        = {2'(ld_lvl_r - 3'd1), POS_W'(ld_idx_r)};
    dis_we       = 1'b0;
    dis_wa       = {lidx_r, hit_pos};
    dis_wd       = ~en_r;

    case (state_r)
      ST_CLR: begin
        dis_we       = 1'b1;
        dis_wa       = clr_addr_r;
        dis_wd       = 1'b0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_DISP: begin
        res_lvl_nxt  = '0;
        res_en_nxt   = 1'b0;
        res_ntf_nxt  = 1'b0;
        res_done_nxt = 1'b0;
        res_id_nxt   = '0;
        lidx_nxt     = 2'd3;       // highest level first: its hit wins
        case (op_r)
          OP_LOAD: begin
            id_we      = ld_ok;
            res_id_nxt = EVT_W'(key_r);
          end
          OP_SET_EN, OP_QUERY: res_id_nxt = EVT_W'(key_r);
          OP_ITER_RST: begin
            iter_lvl_nxt = 3'd1;
            iter_pos_nxt = '0;
          end
          default: ;
        endcase
      end
      ST_LVL: begin
        lo_nxt = '0;
        hi_nxt = POS_W'(cur_cnt - 1'b1);
        if (cur_cnt == '0 && !last_lvl) lidx_nxt = lidx_r - 1'b1;
      end
      ST_MCMP, ST_LCMP, ST_HCMP: begin
        if (key_eq) begin
          res_lvl_nxt = {1'b0, lidx_r} + 3'd1;
          if (op_r == OP_SET_EN) begin
            dis_we      = 1'b1;
            res_en_nxt  = en_r;
            res_ntf_nxt = 1'b1;
          end else begin
            res_en_nxt  = ~dis_rd_r;
          end
        end else if (state_r == ST_MCMP) begin
          lo_nxt = lo_upd;
          hi_nxt = hi_upd;
        end else if (state_r == ST_HCMP && !last_lvl) begin
          lidx_nxt = lidx_r - 1'b1;
        end
      end
      ST_LO: rd_addr = {lidx_r, lo_r};
      ST_HI: rd_addr = {lidx_r, hi_r};
      ST_ITER: begin
        rd_addr = {iter_lidx, iter_pos_r[POS_W-1:0]};
        if (iter_lvl_r == '0) begin
          res_done_nxt = 1'b1;
        end else if (iter_end) begin
          if (iter_lvl_r == 3'd4) begin
            iter_lvl_nxt = '0;
            iter_pos_nxt = '0;
            res_done_nxt = 1'b1;
          end else begin
            iter_lvl_nxt = iter_lvl_r + 3'd1;
            iter_pos_nxt = '0;
          end
        end else begin
          iter_pos_nxt = iter_pos_r + 1'b1;
        end
      end
      ST_ICHK: begin
        if (dis_rd_r) begin
          res_lvl_nxt = iter_lvl_r;
          res_id_nxt  = EVT_W'(id_rd_r);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      iter_lvl_r  <= 3'd1;
      iter_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      iter_lvl_r  <= iter_lvl_nxt;
      iter_pos_r  <= iter_pos_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r     <= op_t'(in_opcode);
      key_r    <= in_event_id[KEY_W-1:0];
      en_r     <= in_enable;
      ld_lvl_r <= in_load_level;
      ld_idx_r <= in_load_index;
    end
    lidx_r     <= lidx_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    res_lvl_r  <= res_lvl_nxt;
    res_en_r   <= res_en_nxt;
    res_ntf_r  <= res_ntf_nxt;
    res_id_r   <= res_id_nxt;
    res_done_r <= res_done_nxt;
    if (out_load) begin
      out_lvl_r  <= res_lvl_r;
      out_en_r   <= res_en_r;
      out_ntf_r  <= res_ntf_r;
      out_id_r   <= res_id_r;
      out_done_r <= res_done_r;
    end
  end

  // ---------------------------------------------------------------------
  // ports
  // ---------------------------------------------------------------------
  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_level_found     = out_lvl_r;
  assign out_is_enabled      = out_en_r;
  assign out_notify_registry = out_ntf_r;
  assign out_reported_id     = out_id_r;
  assign out_iter_done       = out_done_r;

endmodule

// ----- verif/tb_event_id_filter_table.sv -----
// self-checking testbench of the event identifier filter table
`timescale 1ns / 100ps

module tb_event_id_filter_table
  import eift_pkg::*;
();

  // sizes of the default build
  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_SLOTS = 4 * TABLE_DEPTH;
  localparam int OPC_TOP     = (1 << OPC_W) - 1;   // highest code the opcode field can carry
  localparam int MAX_GAP     = 14;                 // longest idle draw on either side
  localparam int LONG_HOLD   = 600;                // receiver hold-off for the pressure test
  localparam int SETTLE      = 8;                  // idle cycles before a count write
  localparam int END_WAIT    = 100;                // watch for stray words at the end

  // register index that maps to no count, written once so every index bit toggles
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = '1;

  // one result word as the block should present it
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             enabled;
    logic             notify;
    logic [EVT_W-1:0] id;
    logic             done;
  } filter_reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OPC_W-1:0]     in_opcode;
  logic [EVT_W-1:0]     in_event_id;
  logic                 in_enable;
  logic [LVL_W-1:0]     in_load_level;
  logic [LIDX_W-1:0]    in_load_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [LVL_W-1:0]     out_level_found;
  logic                 out_is_enabled;
  logic                 out_notify_registry;
  logic [EVT_W-1:0]     out_reported_id;
  logic                 out_iter_done;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_REG_W-1:0] cfg_data;

  event_id_filter_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_event_id         (in_event_id),
    .in_enable           (in_enable),
    .in_load_level       (in_load_level),
    .in_load_index       (in_load_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_level_found     (out_level_found),
    .out_is_enabled      (out_is_enabled),
    .out_notify_registry (out_notify_registry),
    .out_reported_id     (out_reported_id),
    .out_iter_done       (out_iter_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: our own copy of the tables, disable bits, iterator and counts
  // ---------------------------------------------------------------------------
  logic [EVT_W-1:0]     stored_ids [0:TABLE_SLOTS-1];
  bit                   event_off  [0:TABLE_SLOTS-1];
  logic [CNT_REG_W-1:0] level_count_reg [0:3];
  int                   walk_level;   // 1..4 while walking, 0 once past level four
  int                   walk_pos;     // -1 means before the first entry of walk_level

  filter_reply_t reply_q [$];         // expected words, oldest first
  int            mismatch_count = 0;
  int            results_seen   = 0;
  bit            sender_eager   = 1'b0;   // stretch with no idling on the command side
  bit            sink_eager     = 1'b0;   // stretch with no stalling on the result side
  bit            hold_request   = 1'b0;   // asks the result side for one long hold-off

  initial begin
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      stored_ids[s] = '0;
      event_off[s]  = 1'b0;
    end
    for (int l = 0; l < 4; l++) level_count_reg[l] = CNT_RESET;
    walk_level = 1;
    walk_pos   = -1;
  end

  // entries in use in a level, a count above the table depth saturates
  function automatic int level_size(int lvl);
    int c;
    c = level_count_reg[lvl-1];
    return (c > TABLE_DEPTH) ? TABLE_DEPTH : c;
  endfunction

  // fixed halving search of one level: position of key or -1. on an unsorted
  // level the answer is whatever these steps land on, just as in hardware
  function automatic int probe_level(int lvl, logic [EVT_W-1:0] key);
    int n, base, lo, hi, mid;
    n = level_size(lvl);
    if (n == 0) return -1;
    base = (lvl - 1) * TABLE_DEPTH;
    lo   = 0;
    hi   = n - 1;
    while (1) begin
      mid = lo + (hi - lo) / 2;
      if (stored_ids[base+mid] == key) return mid;
      if (stored_ids[base+mid] > key) hi = mid;
      else lo = mid;
      if (hi - lo <= 1) begin
        if (stored_ids[base+lo] == key) return lo;
        if (stored_ids[base+hi] == key) return hi;
        return -1;
      end
    end
    return -1;
  endfunction

  // apply one accepted command to the predictor and return the word it must produce
  function automatic filter_reply_t apply_command(logic [OPC_W-1:0] op, logic [EVT_W-1:0] key,
                                                  logic en, logic [LVL_W-1:0] ll,
                                                  logic [LIDX_W-1:0] li);
    filter_reply_t r;
    int lvl, slot, p;
    r    = '0;
    lvl  = 0;
    slot = 0;
    // duplicates across levels: the highest level that hits wins
    if (op == OP_SET_EN || op == OP_QUERY) begin
      for (int l = 1; l <= 4; l++) begin
        p = probe_level(l, key);
        if (p >= 0) begin
          lvl  = l;
          slot = (l - 1) * TABLE_DEPTH + p;
        end
      end
    end
    case (op)
      OP_LOAD: begin
        // a level outside one to four is dropped, the word still echoes the id
        if (ll >= 1 && ll <= 4) stored_ids[(int'(ll) - 1) * TABLE_DEPTH + int'(li)] = key;
        r.id = key;
      end
      OP_SET_EN: begin
        r.id = key;
        if (lvl != 0) begin
          event_off[slot] = !en;
          r.level   = LVL_W'(lvl);
          r.enabled = en;
          r.notify  = 1'b1;
        end
      end
      OP_QUERY: begin
        r.id = key;
        if (lvl != 0) begin
          r.level   = LVL_W'(lvl);
          r.enabled = !event_off[slot];
        end
      end
      OP_ITER_RST: begin
        walk_level = 1;
        walk_pos   = -1;
      end
      OP_NEXT_DIS: begin
        // walks against the current counts, so a count changed mid-walk takes effect
        while (walk_level >= 1 && walk_level <= 4) begin
          walk_pos++;
          if (walk_pos >= level_size(walk_level)) begin
            if (walk_level == 4) begin
              walk_level = 0;
              walk_pos   = 0;
            end else begin
              walk_level++;
              walk_pos = -1;
            end
          end else begin
            slot = (walk_level - 1) * TABLE_DEPTH + walk_pos;
            if (event_off[slot]) begin
              r.level = LVL_W'(walk_level);
              r.id    = stored_ids[slot];
              return r;
            end
          end
        end
        // exhausted: stays done until the iterator is reset
        walk_level = 0;
        r.done     = 1'b1;
      end
      default: ;   // unused codes change nothing and give an all-zero word
    endcase
    return r;
  endfunction

  function automatic logic [EVT_W-1:0] some_stored_id();
    return stored_ids[$urandom_range(0, TABLE_SLOTS - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_reply();
    filter_reply_t want;
    if (reply_q.size() == 0) begin
      log_mismatch($sformatf("result word %0d with nothing expected", results_seen));
    end else begin
      want = reply_q.pop_front();
      if (out_level_found !== want.level)
        log_mismatch($sformatf("word %0d level_found %0d, expected %0d",
                               results_seen, out_level_found, want.level));
      if (out_is_enabled !== want.enabled)
        log_mismatch($sformatf("word %0d is_enabled %0b, expected %0b",
                               results_seen, out_is_enabled, want.enabled));
      if (out_notify_registry !== want.notify)
        log_mismatch($sformatf("word %0d notify_registry %0b, expected %0b",
                               results_seen, out_notify_registry, want.notify));
      if (out_reported_id !== want.id)
        log_mismatch($sformatf("word %0d reported_id %h, expected %h",
                               results_seen, out_reported_id, want.id));
      if (out_iter_done !== want.done)
        log_mismatch($sformatf("word %0d iter_done %0b, expected %0b",
                               results_seen, out_iter_done, want.done));
    end
    results_seen++;
  endtask

  // sample at the edge: values seen here are the ones the handshake used
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply();
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each word, stretches with none, and one
  // long hold-off on request so the block backs up into its command port
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = sink_eager ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 39) == 0) sink_eager = !sink_eager;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------
  // offer one command word after a random gap and predict it once taken. valid
  // is left high on return, so a back-to-back word never drops it in between
  task automatic issue_command(logic [OPC_W-1:0] op, logic [EVT_W-1:0] key, logic en,
                               logic [LVL_W-1:0] ll, logic [LIDX_W-1:0] li);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) sender_eager = !sender_eager;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_event_id   <= key;
    in_enable     <= en;
    in_load_level <= ll;
    in_load_index <= li;
    do @(posedge clk); while (in_stall);
    reply_q.push_back(apply_command(op, key, en, ll, li));
  endtask

  // stop offering and wait until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // count registers only change while nothing is in flight
  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CNT_REG_W-1:0] val);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= CFG_CNT_L4) level_count_reg[idx[1:0]] = val;
  endtask

  // one command drawn from a mix that mostly hits stored ids, with loads that
  // may unsort or duplicate, ignored loads and unused codes as noise
  task automatic random_command();
    int pick, sel;
    logic [EVT_W-1:0] key;
    logic [LVL_W-1:0] ll;
    logic [LIDX_W-1:0] li;
    logic en;
    pick = $urandom_range(0, 99);
    key  = ($urandom_range(0, 4) != 0) ? some_stored_id() : EVT_W'($urandom());
    en   = 1'($urandom_range(0, 1));
    ll   = LVL_W'($urandom_range(0, OPC_TOP));
    li   = LIDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    if (pick < 30) begin
      issue_command(OP_QUERY, key, en, ll, li);
    end else if (pick < 55) begin
      issue_command(OP_SET_EN, key, en, ll, li);
    end else if (pick < 60) begin
      issue_command(OP_ITER_RST, key, en, ll, li);
    end else if (pick < 80) begin
      issue_command(OP_NEXT_DIS, key, en, ll, li);
    end else if (pick < 90) begin
      // half the time rewrites the id already there, which keeps the level sorted
      ll  = LVL_W'($urandom_range(1, 4));
      sel = $urandom_range(0, 9);
      if (sel < 5) key = stored_ids[(int'(ll) - 1) * TABLE_DEPTH + int'(li)];
      else if (sel < 8) key = some_stored_id();
      else key = EVT_W'($urandom());
      issue_command(OP_LOAD, key, en, ll, li);
    end else if (pick < 95) begin
      sel = $urandom_range(0, 3);
      ll  = LVL_W'((sel == 0) ? 0 : sel + 4);   // level zero or five to seven
      issue_command(OP_LOAD, key, en, ll, li);
    end else begin
      issue_command(OPC_W'($urandom_range(OP_NEXT_DIS + 1, OPC_TOP)), key, en, ll, li);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // fill every entry of all four levels: one ascending run of unique ids from
  // zero to all ones, spread at random over the levels so each stays sorted.
  // steps of at least two leave one and all-ones-minus-one unused
  task automatic test_table_fill();
    int fill [4];
    int lvl;
    logic [EVT_W-1:0] val;
    fill = '{default: 0};
    val  = '0;
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (k == TABLE_SLOTS - 1) val = '1;
      else if (k > 0) val = val + EVT_W'($urandom_range(2, 250));
      do lvl = $urandom_range(0, 3); while (fill[lvl] == TABLE_DEPTH);
      issue_command(OP_LOAD, val, 1'($urandom_range(0, 1)), LVL_W'(lvl + 1),
                    LIDX_W'(fill[lvl]));
      fill[lvl]++;
    end
  endtask

  // extremes of the id, every command, misses, the iterator to its end and beyond,
  // ignored loads and the unused codes
  task automatic test_directed_cases();
    logic [EVT_W-1:0] mid_id;
    mid_id = stored_ids[TABLE_SLOTS / 2 + 5];
    issue_command(OP_QUERY, '0, 1'b0, '0, '0);
    issue_command(OP_QUERY, '1, 1'b1, '1, '1);
    issue_command(OP_QUERY, EVT_W'(1), 1'b0, '0, '0);         // never stored
    issue_command(OP_SET_EN, '0, 1'b0, '0, '0);
    issue_command(OP_SET_EN, '1, 1'b0, '1, '1);
    issue_command(OP_SET_EN, mid_id, 1'b0, '0, '0);
    issue_command(OP_SET_EN, ~EVT_W'(1), 1'b0, '0, '0);       // miss, no notify
    issue_command(OP_QUERY, '0, 1'b1, '0, '0);
    issue_command(OP_QUERY, mid_id, 1'b1, '0, '0);
    issue_command(OP_ITER_RST, '1, 1'b1, '1, '1);
    repeat (5) issue_command(OP_NEXT_DIS, '0, 1'b0, '0, '0);  // three hits, then done twice
    issue_command(OP_SET_EN, '1, 1'b1, '0, '0);
    issue_command(OP_QUERY, '1, 1'b0, '0, '0);
    // loads to no level must leave the tables alone
    issue_command(OP_LOAD, '1, 1'b1, '0, '1);
    issue_command(OP_LOAD, '0, 1'b0, LVL_W'(5), '0);
    issue_command(OP_LOAD, '1, 1'b1, '1, '1);
    issue_command(OP_QUERY, '0, 1'b0, '0, '0);
    for (int c = OP_NEXT_DIS + 1; c <= OPC_TOP; c++)
      issue_command(OPC_W'(c), '1, 1'b1, '1, '1);
    issue_command(OP_ITER_RST, '0, 1'b0, '0, '0);
  endtask

  // counts at zero, one, the depth and beyond it on every level in turn, then a
  // count pulled below the iterator while it is walking
  task automatic test_level_counts();
    int extremes [4];
    int lw;
    extremes = '{0, 1, TABLE_DEPTH, (1 << CNT_REG_W) - 1};
    for (int r = 0; r < 4; r++) begin
      for (int l = 0; l < 4; l++)
        write_count(CFG_IDX_W'(l), CNT_REG_W'(extremes[(l + r) % 4]));
      repeat (12) random_command();
      issue_command(OP_ITER_RST, '0, 1'b0, '0, '0);
      repeat (6) issue_command(OP_NEXT_DIS, some_stored_id(), 1'b1, '0, '0);
    end
    for (int l = 0; l < 4; l++) write_count(CFG_IDX_W'(l), CNT_RESET);
    // disable a good spread of entries so the walk has something to find
    repeat (16) issue_command(OP_SET_EN, some_stored_id(), 1'b0, '0, '0);
    issue_command(OP_ITER_RST, '0, 1'b0, '0, '0);
    repeat (2) issue_command(OP_NEXT_DIS, '0, 1'b0, '0, '0);
    lw = (walk_level == 0) ? 1 : walk_level;
    write_count(CFG_IDX_W'(lw - 1), CNT_REG_W'($urandom_range(0, walk_pos + 1)));
    repeat (4) issue_command(OP_NEXT_DIS, '0, 1'b0, '0, '0);
    for (int l = 0; l < 4; l++) write_count(CFG_IDX_W'(l), CNT_RESET);
    write_count(CFG_SPARE_IDX, '1);   // no register there, nothing may change
  endtask

  // the result side holds off for a long stretch while words keep coming
  task automatic test_output_backpressure();
    drain_results();
    hold_request = 1'b1;
    sender_eager = 1'b1;
    repeat (30) random_command();
    sender_eager = 1'b0;
  endtask

  task automatic test_random_traffic(int words, bit new_counts);
    if (new_counts)
      for (int l = 0; l < 4; l++) write_count(CFG_IDX_W'(l), CNT_REG_W'($urandom_range(1, 64)));
    repeat (words) random_command();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_LOAD;
    in_event_id   <= '0;
    in_enable     <= 1'b0;
    in_load_level <= '0;
    in_load_index <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_CNT_L1;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the block sweeps its disable bits first, the handshake simply waits it out
    test_table_fill();
    test_directed_cases();
    test_level_counts();
    test_output_backpressure();
    test_random_traffic(420, 1'b0);
    test_table_fill();            // fresh sorted tables after the scrambling loads
    test_random_traffic(260, 1'b1);
    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // guard against a hang: several times the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/eift_pkg.sv
hw/rtl/event_id_filter_table.sv
verif/tb_event_id_filter_table.sv
